>>> rtl/core/fsbc_pkg.sv
package fsbc_pkg;

    // Field widths of a packed plane register
    localparam int NORMAL_BITS    = 14;
    localparam int INTERCEPT_BITS = 22;
    localparam int PLANE_COUNT    = 6;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;

    // Q1.12 normal times intercept alignment: Q.8 -> Q.20
    localparam int Q_SHIFT = 12;

    // |nx|+|ny|+|nz| never exceeds 3 * 2^13
    localparam int ABS_SUM_BITS = NORMAL_BITS + 1;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] PLANE_RIGHT  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] PLANE_LEFT   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] PLANE_BOTTOM = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] PLANE_TOP    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] PLANE_BACK   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] PLANE_FRONT  = 3'd5;

    // Query kinds
    localparam logic CMD_SPHERE = 1'b0;
    localparam logic CMD_CUBE   = 1'b1;

    // Register layout: d in [63:42], nz [41:28], ny [27:14], nx [13:0]
    typedef struct packed {
        logic signed [INTERCEPT_BITS-1:0] d;
        logic signed [NORMAL_BITS-1:0]    nz;
        logic signed [NORMAL_BITS-1:0]    ny;
        logic signed [NORMAL_BITS-1:0]    nx;
    } plane_t;

    // Stored plane plus its precomputed L1 norm for the cube reach
    typedef struct packed {
        plane_t                  plane;
        logic [ABS_SUM_BITS-1:0] abs_sum;
    } plane_cfg_t;

    function automatic logic [NORMAL_BITS-1:0] abs_normal(
        input logic signed [NORMAL_BITS-1:0] v
    );
        logic [NORMAL_BITS-1:0] r;
        begin
            // most negative value maps to 2^13, still correct as unsigned
            r = v[NORMAL_BITS-1] ? NORMAL_BITS'(-v) : NORMAL_BITS'(v);
            return r;
        end
    endfunction

    function automatic logic [ABS_SUM_BITS-1:0] normal_abs_sum(input plane_t p);
        logic [ABS_SUM_BITS-1:0] s;
        begin
            s = ABS_SUM_BITS'(abs_normal(p.nx)) + ABS_SUM_BITS'(abs_normal(p.ny))
                + ABS_SUM_BITS'(abs_normal(p.nz));
            return s;
        end
    endfunction

endpackage

>>> rtl/core/fsbc_plane_regs.sv
module fsbc_plane_regs (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            cfg_valid,
    input  logic [fsbc_pkg::CFG_INDEX_BITS-1:0]             cfg_index,
    input  logic [fsbc_pkg::CFG_DATA_BITS-1:0]              cfg_data,
    output fsbc_pkg::plane_cfg_t [fsbc_pkg::PLANE_COUNT-1:0] planes
);

    fsbc_pkg::plane_t plane_wr;

    assign plane_wr = fsbc_pkg::plane_t'(cfg_data);

    // One register per plane; L1 norm computed once at write time
    for (genvar i = 0; i < fsbc_pkg::PLANE_COUNT; i++) begin : g_plane
        fsbc_pkg::plane_cfg_t plane_reg;
        fsbc_pkg::plane_cfg_t plane_next;
        logic                 hit;

        assign hit = cfg_valid && (cfg_index == fsbc_pkg::CFG_INDEX_BITS'(i));

        always_comb
        begin
            plane_next = plane_reg;
            if (hit)
            begin
                plane_next.plane   = plane_wr;
                plane_next.abs_sum = fsbc_pkg::normal_abs_sum(plane_wr);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                plane_reg <= '0;
            end
            else
            begin
                plane_reg <= plane_next;
            end
        end

        assign planes[i] = plane_reg;
    end

endmodule

>>> rtl/core/fsbc_plane_eval.sv
module fsbc_plane_eval #(
    parameter int COORD_BITS = 22
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic                         cube,
    input  logic signed [COORD_BITS-1:0] center_x,
    input  logic signed [COORD_BITS-1:0] center_y,
    input  logic signed [COORD_BITS-1:0] center_z,
    input  logic [COORD_BITS-2:0]        extent,
    input  fsbc_pkg::plane_cfg_t         plane_cfg,
    output logic                         reject
);

    localparam int PROD_W  = COORD_BITS + fsbc_pkg::NORMAL_BITS;
    localparam int DQ_W    = fsbc_pkg::INTERCEPT_BITS + fsbc_pkg::Q_SHIFT;
    localparam int REACH_W = COORD_BITS - 1 + fsbc_pkg::ABS_SUM_BITS;
    localparam int SUM_W   = ((PROD_W > DQ_W) ? PROD_W : DQ_W) + 3;

    logic signed [PROD_W-1:0] px_reg, px_next;
    logic signed [PROD_W-1:0] py_reg, py_next;
    logic signed [PROD_W-1:0] pz_reg, pz_next;
    logic [REACH_W-1:0]       off_a_reg, off_a_next;
    logic signed [SUM_W-1:0]  dist_reg, dist_next;
    logic [REACH_W-1:0]       off_b_reg;
    logic signed [SUM_W-1:0]  total;
    logic                     reject_reg, reject_next;

    // Stage A: normal times centre, and the offset toward the plane
    always_comb
    begin
        px_next = PROD_W'(plane_cfg.plane.nx) * PROD_W'(center_x);
        py_next = PROD_W'(plane_cfg.plane.ny) * PROD_W'(center_y);
        pz_next = PROD_W'(plane_cfg.plane.nz) * PROD_W'(center_z);
        if (cube == fsbc_pkg::CMD_CUBE)
        begin
            // nearest-to-inside corner lies s*|n|_1 ahead of the centre
            off_a_next = REACH_W'(extent) * REACH_W'(plane_cfg.abs_sum);
        end
        else
        begin
            off_a_next = REACH_W'(extent) << fsbc_pkg::Q_SHIFT;
        end
    end

    // Stage B: signed distance in Q.20
    always_comb
    begin
        dist_next = SUM_W'(px_reg) + SUM_W'(py_reg) + SUM_W'(pz_reg)
                    + (SUM_W'(plane_cfg.plane.d) <<< fsbc_pkg::Q_SHIFT);
    end

    // Stage C: rejected when distance plus offset is not positive
    always_comb
    begin
        total       = dist_reg + SUM_W'($signed({1'b0, off_b_reg}));
        reject_next = total[SUM_W-1] || (total == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg     <= px_next;
            py_reg     <= py_next;
            pz_reg     <= pz_next;
            off_a_reg  <= off_a_next;
            dist_reg   <= dist_next;
            off_b_reg  <= off_a_reg;
            reject_reg <= reject_next;
        end
    end

    assign reject = reject_reg;

endmodule

>>> rtl/core/frustum_sphere_box_cull_unit.sv
// Frustum culling of spheres and axis-aligned cubes against six configured
// planes. One query is taken every cycle unless the output stalls; a result
// passes four register stages (multiply, distance sum, plane compare, output
// register), with all six planes tested in parallel lanes. A stalled output
// holds the whole pipeline, so in_ready follows out_ready while a result is
// waiting. Planes reset to zero, rejecting every cube and zero-extent sphere
// until loaded. Config writes are always taken; an index above 5 is dropped.
module frustum_sphere_box_cull_unit #(
    parameter int COORD_BITS = 22
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fsbc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [fsbc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic signed [COORD_BITS-1:0]        center_x,
    input  logic signed [COORD_BITS-1:0]        center_y,
    input  logic signed [COORD_BITS-1:0]        center_z,
    input  logic [COORD_BITS-2:0]               extent,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                inside_res
);

    fsbc_pkg::plane_cfg_t [fsbc_pkg::PLANE_COUNT-1:0] planes;
    logic [fsbc_pkg::PLANE_COUNT-1:0]                 reject;
    logic en;
    logic valid_a_reg, valid_b_reg, valid_c_reg, out_valid_reg;
    logic inside_reg, inside_next;

    assign cfg_ready = 1'b1;

    fsbc_plane_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes)
    );

    // One lane per plane
    for (genvar i = 0; i < fsbc_pkg::PLANE_COUNT; i++) begin : g_lane
        fsbc_plane_eval #(
            .COORD_BITS (COORD_BITS)
        ) u_eval (
            .clk       (clk),
            .en        (en),
            .cube      (command),
            .center_x  (center_x),
            .center_y  (center_y),
            .center_z  (center_z),
            .extent    (extent),
            .plane_cfg (planes[i]),
            .reject    (reject[i])
        );
    end

    // Pipeline advances whenever the output register is free or drains
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign inside_next = ~|reject;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg   <= 1'b0;
            valid_b_reg   <= 1'b0;
            valid_c_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg   <= in_valid;
            valid_b_reg   <= valid_a_reg;
            valid_c_reg   <= valid_b_reg;
            out_valid_reg <= valid_c_reg;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inside_reg <= inside_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;

endmodule

>>> tb/sv/frustum_sphere_box_cull_unit_tb.sv
module frustum_sphere_box_cull_unit_tb;

    localparam int COORD_BITS     = 22;
    localparam int EXTENT_BITS    = COORD_BITS - 1;
    localparam int COORD_MAX      = (1 << (COORD_BITS - 1)) - 1;
    localparam int COORD_MIN      = -(1 << (COORD_BITS - 1));
    localparam int EXTENT_MAX     = (1 << EXTENT_BITS) - 1;
    localparam int NORMAL_ONE     = 1 << fsbc_pkg::Q_SHIFT;
    localparam int NORMAL_MAX     = (1 << (fsbc_pkg::NORMAL_BITS - 1)) - 1;
    localparam int NORMAL_MIN     = -(1 << (fsbc_pkg::NORMAL_BITS - 1));
    localparam int INTERCEPT_MAX  = (1 << (fsbc_pkg::INTERCEPT_BITS - 1)) - 1;
    localparam int INTERCEPT_MIN  = -(1 << (fsbc_pkg::INTERCEPT_BITS - 1));
    localparam int Q8_ONE         = 256;
    localparam int PIPE_LATENCY   = 4;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 1000;

    // register indexes past the last plane; writes there must be dropped
    localparam logic [fsbc_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [fsbc_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_B = 3'd7;

    logic                                  clk        = 1'b0;
    logic                                  rst_n      = 1'b0;
    logic                                  cfg_valid  = 1'b0;
    logic                                  cfg_ready;
    logic [fsbc_pkg::CFG_INDEX_BITS-1:0]   cfg_index  = '0;
    logic [fsbc_pkg::CFG_DATA_BITS-1:0]    cfg_data   = '0;
    logic                                  in_valid   = 1'b0;
    logic                                  in_ready;
    logic                                  command    = fsbc_pkg::CMD_SPHERE;
    logic signed [COORD_BITS-1:0]          center_x   = '0;
    logic signed [COORD_BITS-1:0]          center_y   = '0;
    logic signed [COORD_BITS-1:0]          center_z   = '0;
    logic [EXTENT_BITS-1:0]                extent     = '0;
    logic                                  out_valid;
    logic                                  out_ready  = 1'b0;
    logic                                  inside_res;

    // shadow copy of the plane registers
    fsbc_pkg::plane_t plane_cfg [fsbc_pkg::PLANE_COUNT] = '{default: '0};

    bit          inside_expected [$];
    bit          want_inside;
    int unsigned result_index = 0;
    int          error_count  = 0;
    int          idle_cycles  = 0;
    int          stall_left   = 0;
    int          in_idle_pct  = 20;
    int          out_stall_pct = 20;

    frustum_sphere_box_cull_unit #(
        .COORD_BITS(COORD_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .center_x  (center_x),
        .center_y  (center_y),
        .center_z  (center_z),
        .extent    (extent),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .inside_res(inside_res)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor: exact Q.20 plane distances against the shadow planes
    // ---------------------------------------------------------------
    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit frustum_inside(
        input logic                         cmd,
        input logic signed [COORD_BITS-1:0] cx,
        input logic signed [COORD_BITS-1:0] cy,
        input logic signed [COORD_BITS-1:0] cz,
        input logic [EXTENT_BITS-1:0]       ext
    );
        fsbc_pkg::plane_t pl;
        longint nx, ny, nz, plane_dist, reach, r;
        bit     visible;
        visible = 1'b1;
        r = longint'(ext);
        for (int i = 0; i < fsbc_pkg::PLANE_COUNT; i++)
        begin
            pl   = plane_cfg[i];
            nx   = longint'($signed(pl.nx));
            ny   = longint'($signed(pl.ny));
            nz   = longint'($signed(pl.nz));
            plane_dist = nx * longint'(cx) + ny * longint'(cy) + nz * longint'(cz)
                         + longint'($signed(pl.d)) * NORMAL_ONE;
            if (cmd == fsbc_pkg::CMD_CUBE)
            begin
                // farthest corner along the normal
                reach = r * (magnitude(nx) + magnitude(ny) + magnitude(nz));
                if (plane_dist + reach <= 0)
                    visible = 1'b0;
            end
            else if (plane_dist <= -(r * NORMAL_ONE))
            begin
                visible = 1'b0;
            end
        end
        return visible;
    endfunction

    function automatic logic [fsbc_pkg::CFG_DATA_BITS-1:0] pack_plane(
        input int nx,
        input int ny,
        input int nz,
        input int d
    );
        fsbc_pkg::plane_t p;
        p.nx = nx[fsbc_pkg::NORMAL_BITS-1:0];
        p.ny = ny[fsbc_pkg::NORMAL_BITS-1:0];
        p.nz = nz[fsbc_pkg::NORMAL_BITS-1:0];
        p.d  = d[fsbc_pkg::INTERCEPT_BITS-1:0];
        return p;
    endfunction

    // no gap with probability 100-pct percent, otherwise short, now and then long
    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(0, 9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return 0;
            default: return int'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // ---------------------------------------------------------------
    // Configuration writes (only issued while the pipeline is empty)
    // ---------------------------------------------------------------
    task automatic write_plane(
        input logic [fsbc_pkg::CFG_INDEX_BITS-1:0] idx,
        input logic [fsbc_pkg::CFG_DATA_BITS-1:0]  word
    );
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do @(posedge clk); while (!cfg_ready);
        if (idx < fsbc_pkg::PLANE_COUNT)
            plane_cfg[idx] = word;
    endtask

    task automatic end_cfg();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Box frustum: even indexes face -axis, odd face +axis, all inward
    task automatic load_box(input int box, input int tilt, input int jitter);
        int n [3];
        int axis;
        int d;
        for (int i = 0; i < fsbc_pkg::PLANE_COUNT; i++)
        begin
            axis = i / 2;
            for (int k = 0; k < 3; k++)
                n[k] = int'($urandom_range(0, 2 * tilt)) - tilt;
            n[axis] = ((i % 2 == 0) ? -1 : 1)
                      * (NORMAL_ONE + int'($urandom_range(0, 2 * tilt)));
            d = box + int'($urandom_range(0, 2 * jitter)) - jitter;
            write_plane(fsbc_pkg::CFG_INDEX_BITS'(i), pack_plane(n[0], n[1], n[2], d));
        end
        end_cfg();
    endtask

    // ---------------------------------------------------------------
    // Query side
    // ---------------------------------------------------------------
    task automatic send_query(
        input logic cmd,
        input int   cx,
        input int   cy,
        input int   cz,
        input int   ext
    );
        int                           gap;
        logic signed [COORD_BITS-1:0] qx, qy, qz;
        logic [EXTENT_BITS-1:0]       qe;
        qx  = cx[COORD_BITS-1:0];
        qy  = cy[COORD_BITS-1:0];
        qz  = cz[COORD_BITS-1:0];
        qe  = ext[EXTENT_BITS-1:0];
        gap = pick_gap(in_idle_pct);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        center_x <= qx;
        center_y <= qy;
        center_z <= qz;
        extent   <= qe;
        do @(posedge clk); while (!in_ready);
        inside_expected.push_back(frustum_inside(cmd, qx, qy, qz, qe));
    endtask

    task automatic send_wild_query();
        int ext;
        case ($urandom_range(0, 9))
            0, 1: ext = 0;
            2:    ext = EXTENT_MAX;
            default: ext = $urandom_range(0, EXTENT_MAX);
        endcase
        send_query($urandom_range(0, 1) ? fsbc_pkg::CMD_CUBE : fsbc_pkg::CMD_SPHERE,
                   pick_coord(), pick_coord(), pick_coord(), ext);
    endtask

    // centre within twice the box, extent mostly small against the box
    task automatic send_box_query(input int box);
        int span;
        int ext;
        int sel;
        span = 2 * box;
        sel  = $urandom_range(0, 9);
        if (sel < 6)
            ext = $urandom_range(0, box / 4);
        else if (sel < 9)
            ext = $urandom_range(0, 2 * box);
        else
            ext = $urandom_range(0, EXTENT_MAX);
        send_query($urandom_range(0, 1) ? fsbc_pkg::CMD_CUBE : fsbc_pkg::CMD_SPHERE,
                   int'($urandom_range(0, 2 * span)) - span,
                   int'($urandom_range(0, 2 * span)) - span,
                   int'($urandom_range(0, 2 * span)) - span,
                   ext);
    endtask

    // stop sending and wait until every expected result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (inside_expected.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Result side: random back-pressure and checking
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            stall_left = pick_gap(out_stall_pct);
            if (stall_left > 0)
            begin
                out_ready  <= 1'b0;
                stall_left = stall_left - 1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (inside_expected.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                          result_index));
            end
            else
            begin
                want_inside = inside_expected.pop_front();
                if (inside_res !== want_inside)
                    report_mismatch($sformatf("inside_res got %0b want %0b on result %0d",
                                              inside_res, want_inside, result_index));
            end
            result_index++;
        end
    end

    // watchdog on stretches with no transfer at all
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // zeroed planes reject every cube and every zero-extent sphere
    task automatic test_reset_planes();
        send_query(fsbc_pkg::CMD_SPHERE, 0, 0, 0, 0);
        send_query(fsbc_pkg::CMD_CUBE, 0, 0, 0, 0);
        send_query(fsbc_pkg::CMD_SPHERE, 0, 0, 0, EXTENT_MAX);
        send_query(fsbc_pkg::CMD_CUBE, 0, 0, 0, EXTENT_MAX);
        send_query(fsbc_pkg::CMD_SPHERE, COORD_MAX, COORD_MIN, COORD_MAX, EXTENT_MAX);
        send_query(fsbc_pkg::CMD_CUBE, COORD_MIN, COORD_MAX, COORD_MIN, EXTENT_MAX);
        drain_results();
    endtask

    // axis-aligned box of half side 100.0, touching cases on each side
    task automatic test_box_edges();
        int box;
        box = 100 * Q8_ONE;
        load_box(box, 0, 0);
        send_query(fsbc_pkg::CMD_SPHERE, 0, 0, 0, 0);
        send_query(fsbc_pkg::CMD_SPHERE, box + Q8_ONE, 0, 0, Q8_ONE);
        send_query(fsbc_pkg::CMD_SPHERE, box + Q8_ONE - 1, 0, 0, Q8_ONE);
        send_query(fsbc_pkg::CMD_CUBE, box + Q8_ONE, 0, 0, Q8_ONE);
        send_query(fsbc_pkg::CMD_CUBE, box + Q8_ONE - 1, 0, 0, Q8_ONE);
        send_query(fsbc_pkg::CMD_CUBE, box, 0, 0, 0);
        send_query(fsbc_pkg::CMD_CUBE, box - 1, 0, 0, 0);
        send_query(fsbc_pkg::CMD_SPHERE, -box, 0, 0, 0);
        send_query(fsbc_pkg::CMD_SPHERE, 0, box + 10, 0, 10);
        send_query(fsbc_pkg::CMD_CUBE, 0, 0, -(box + 10), 10);
        send_query(fsbc_pkg::CMD_SPHERE, COORD_MAX, COORD_MAX, COORD_MAX, EXTENT_MAX);
        send_query(fsbc_pkg::CMD_CUBE, COORD_MIN, COORD_MIN, COORD_MIN, EXTENT_MAX);
        send_query(fsbc_pkg::CMD_SPHERE, COORD_MIN, COORD_MAX, 0, 0);
        send_query(fsbc_pkg::CMD_CUBE, 0, 0, 0, EXTENT_MAX);
        drain_results();
    endtask

    // random boxes with tilted planes, varying idle and back-pressure
    task automatic test_random_boxes();
        int box;
        int tilt;
        for (int ph = 0; ph < 8; ph++)
        begin
            drain_results();
            box  = (1 << $urandom_range(8, 19)) | $urandom_range(0, 255);
            tilt = (ph == 0) ? 0 : $urandom_range(0, 1024);
            load_box(box, tilt, box / 8);
            if (ph % 4 == 0)
            begin
                in_idle_pct   = 0;
                out_stall_pct = 0;
            end
            else
            begin
                in_idle_pct   = $urandom_range(5, 40);
                out_stall_pct = (ph == 3) ? 80 : $urandom_range(5, 40);
            end
            for (int n = 0; n < 160; n++)
            begin
                // sender holds off until the pipeline is empty
                if (n == 80 && ph % 2 == 1)
                    drain_results();
                if ($urandom_range(0, 99) < 85)
                    send_box_query(box);
                else
                    send_wild_query();
            end
        end
        drain_results();
    endtask

    // extreme register contents, plus writes to unused indexes
    task automatic test_extreme_planes();
        logic [fsbc_pkg::CFG_DATA_BITS-1:0] word;
        in_idle_pct   = 25;
        out_stall_pct = 25;
        for (int s = 0; s < 5; s++)
        begin
            drain_results();
            for (int i = 0; i < fsbc_pkg::PLANE_COUNT; i++)
            begin
                case (s)
                    0: word = '1;
                    1: word = (i % 2 == 0)
                              ? pack_plane(NORMAL_MIN, NORMAL_MIN, NORMAL_MIN, INTERCEPT_MIN)
                              : pack_plane(NORMAL_MAX, NORMAL_MAX, NORMAL_MAX, INTERCEPT_MAX);
                    2: word = pack_plane(NORMAL_MAX, NORMAL_MAX, NORMAL_MAX, INTERCEPT_MAX);
                    3: word = pack_plane(0, 0, 0, INTERCEPT_MAX);
                    default: word = {$urandom, $urandom};
                endcase
                write_plane(fsbc_pkg::CFG_INDEX_BITS'(i), word);
            end
            write_plane(CFG_SPARE_A, '0);
            write_plane(CFG_SPARE_B, {$urandom, $urandom});
            end_cfg();
            for (int n = 0; n < 50; n++)
            begin
                if (n % 2 == 0)
                    send_wild_query();
                else
                    send_box_query(1 << 12);
            end
        end
        drain_results();
    endtask

    // full-rate burst, then heavy output back-pressure
    task automatic test_back_to_back();
        drain_results();
        load_box(1 << 14, 512, 1 << 10);
        in_idle_pct   = 0;
        out_stall_pct = 0;
        for (int n = 0; n < 100; n++)
            send_box_query(1 << 14);
        out_stall_pct = 70;
        for (int n = 0; n < 100; n++)
            send_box_query(1 << 14);
        drain_results();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_planes();
        test_box_edges();
        test_random_boxes();
        test_extreme_planes();
        test_back_to_back();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
